### rtl/core/keyframe_curve_evaluator_assert.svh
// Assertion macros for the keyframe curve evaluator.
// Used by keyframe_curve_evaluator.sv; no other dependencies.
`ifndef KEYFRAME_CURVE_EVALUATOR_ASSERT_SVH
`define KEYFRAME_CURVE_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KCE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("kce: same-cycle check failed");
// next-cycle implication
`define KCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("kce: next-cycle check failed");
`else
`define KCE_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define KCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/kce_pkg.sv
// Shared types, codes and helpers of the keyframe curve evaluator.
// No dependencies.
package kce_pkg;

	localparam logic       REQ_WRITE    = 1'b0;
	localparam logic       REQ_EVAL     = 1'b1;
	localparam logic [1:0] MODE_CONST   = 2'd0;
	localparam logic [1:0] MODE_LINEAR  = 2'd1;
	localparam logic [1:0] MODE_CUBIC   = 2'd2;
	localparam logic [1:0] MODE_BAD     = 2'd3;
	localparam logic [1:0] STAT_EVAL    = 2'd0;
	localparam logic [1:0] STAT_WRITTEN = 2'd1;
	localparam logic [1:0] STAT_REJECT  = 2'd2;
	localparam int         QDEPTH       = 2;
	localparam int         ACC_W        = 50;

	typedef struct packed {
		logic               req_type;
		logic [3:0]         key_index;
		logic signed [31:0] key_time;
		logic signed [31:0] key_value;
		logic signed [31:0] key_in_tangent;
		logic signed [31:0] key_out_tangent;
		logic [1:0]         key_mode;
		logic signed [31:0] eval_time;
	} req_t;

	typedef struct packed {
		logic signed [31:0] curve_value;
		logic [1:0]         status;
	} res_t;

	typedef enum logic [1:0] {
		JOB_WRITE  = 2'd0,
		JOB_REJECT = 2'd1,
		JOB_EVAL   = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		req_t      req;
	} job_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} qstat_t;

	typedef struct packed {
		logic signed [31:0] ktime;
		logic signed [31:0] kvalue;
		logic signed [31:0] kin;
		logic signed [31:0] kout;
		logic [1:0]         kmode;
	} krec_t;

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sd2147483647);
		lo = ACC_W'(-64'sd2147483648);
		if (x > hi) begin
			return 32'sh7fffffff;
		end else if (x < lo) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

endpackage

### rtl/core/keyframe_curve_evaluator.sv
// Keyframe curve evaluator top level: front end, job queue, back end.
// Depends on kce_pkg, kce_front, kce_queue, kce_back and the assertion header.
//
//  channel  handshake                 payload
//  request  start & !busy             req  (kce_pkg::req_t)
//  result   done, one-cycle strobe    res  (kce_pkg::res_t)
//  config   cfg_valid & cfg_ready     cfg_data (key_count)
//
// A key write or reject is taken from the queue head in S_IDLE; S_START sets the done strobe.
// An evaluation checks the end keys, scans keys one by one (up to N-1), runs the alpha
// divide, selects the mode, then forms the linear product or, for cubic, runs eight
// multiply steps plus basis setup; it ends early at an end key or a constant mode.
// Reset clears the key count and control; the table holds garbage until written.
// The result side cannot stall; busy rises only when the two-entry queue fills.
`include "keyframe_curve_evaluator_assert.svh"
module keyframe_curve_evaluator #(
	parameter int MAX_KEYS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kce_pkg::req_t req,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [4:0]    cfg_data,
	output logic          done,
	output kce_pkg::res_t res
);

	logic            push;
	logic            pop;
	kce_pkg::job_t   push_job;
	kce_pkg::job_t   head;
	kce_pkg::qstat_t qstat;
	logic [4:0]      key_count_q;

	// key count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			key_count_q <= cfg_data;
		end
	end
	assign cfg_ready = 1'b1;
	assign busy      = qstat.full;

	kce_front #(.MAX_KEYS(MAX_KEYS)) u_front (
		.start (start),
		.busy  (busy),
		.req   (req),
		.push  (push),
		.job   (push_job)
	);

	kce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	kce_back #(.MAX_KEYS(MAX_KEYS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_count (key_count_q),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.done      (done),
		.res       (res)
	);

	// checks
	`KCE_ASSERT_NEXT(a_push_lands, clk, arst_n, start && !busy, !qstat.empty)
	`KCE_ASSERT_SAME(a_write_zero, clk, arst_n, done && (res.status != kce_pkg::STAT_EVAL), res.curve_value == 0)
	`KCE_ASSERT_NEXT(a_strobe_single, clk, arst_n, done, !done)

endmodule

### rtl/core/kce_front.sv
// Front end: takes requests and classifies them into queue jobs.
// Depends on kce_pkg.
module kce_front #(
	parameter int MAX_KEYS = 16
) (
	input  logic          start,
	input  logic          busy,
	input  kce_pkg::req_t req,
	output logic          push,
	output kce_pkg::job_t job
);

	logic bad_write;

	// write with bad mode or slot is rejected
	assign bad_write = (req.key_mode == kce_pkg::MODE_BAD) || (32'(req.key_index) >= MAX_KEYS);

	always_comb begin
		job.req = req;
		if (req.req_type == kce_pkg::REQ_EVAL) begin
			job.kind = kce_pkg::JOB_EVAL;
		end else if (bad_write) begin
			job.kind = kce_pkg::JOB_REJECT;
		end else begin
			job.kind = kce_pkg::JOB_WRITE;
		end
	end

	assign push = start && !busy;

endmodule

### rtl/core/kce_queue.sv
// Two-entry job queue between front and back end.
// Depends on kce_pkg.
module kce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kce_pkg::job_t  push_job,
	input  logic           pop,
	output kce_pkg::job_t  head,
	output kce_pkg::qstat_t qstat
);

	kce_pkg::job_t slot_q [kce_pkg::QDEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	assign head        = slot_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.full  = (count_q == 2'(kce_pkg::QDEPTH));
	assign qstat.empty = (count_q == 2'd0);

endmodule

### rtl/core/kce_back.sv
// Back end: key table memory and the evaluation sequencer
// (segment scan, serial divide, shared multiplier). Depends on kce_pkg.
module kce_back #(
	parameter int MAX_KEYS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [4:0]      key_count,
	input  kce_pkg::qstat_t qstat,
	input  kce_pkg::job_t   head,
	output logic            pop,
	output logic            done,
	output kce_pkg::res_t   res
);

	localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int KW = (CW > 5) ? CW : 5;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_START = 12'b000000000010,
		S_CK0   = 12'b000000000100,
		S_CKL   = 12'b000000001000,
		S_SCAN  = 12'b000000010000,
		S_DIVI  = 12'b000000100000,
		S_DIV   = 12'b000001000000,
		S_MODE  = 12'b000010000000,
		S_MUL   = 12'b000100000000,
		S_ACC   = 12'b001000000000,
		S_HERM  = 12'b010000000000,
		S_SPARE = 12'b100000000000
	} state_t;

	typedef enum logic [3:0] {
		ST_LIN, ST_A2, ST_A3, ST_H00, ST_H01, ST_P10, ST_S10, ST_P11, ST_S11
	} step_t;

	kce_pkg::krec_t key_mem [MAX_KEYS];
	kce_pkg::krec_t rd_data_q;
	logic [IW-1:0]  rd_addr;
	logic           wr_en;
	kce_pkg::krec_t wr_rec;

	state_t                       state_q;
	step_t                        step_q;
	kce_pkg::job_t                job_q;
	kce_pkg::krec_t               prev_q;
	kce_pkg::krec_t               left_q;
	kce_pkg::krec_t               right_q;
	logic [IW-1:0]                idx_q;
	logic signed [32:0]           span_q;
	logic signed [32:0]           off_q;
	logic [33:0]                  rem_q;
	logic [15:0]                  quo_q;
	logic [3:0]                   dcnt_q;
	logic [16:0]                  a_q;
	logic [15:0]                  a2_q;
	logic [15:0]                  a3_q;
	logic signed [19:0]           h00_q, h10_q, h01_q, h11_q;
	logic signed [31:0]           p_q;
	logic signed [67:0]           prod_q;
	logic signed [kce_pkg::ACC_W-1:0] acc_q;
	logic                         done_q;
	kce_pkg::res_t                res_q;

	logic [CW-1:0]      n_keys;
	logic [IW-1:0]      last_idx;
	logic signed [31:0] t_eval;
	logic signed [32:0] span_c, off_c;
	logic [33:0]        rem2;
	logic               qbit;
	logic signed [33:0] opa, opb;
	logic signed [kce_pkg::ACC_W-1:0] term;
	logic signed [19:0] a2e, a3e, ae;

	// effective key count
	always_comb begin
		if (KW'(key_count) > KW'(MAX_KEYS)) begin
			n_keys = CW'(MAX_KEYS);
		end else begin
			n_keys = CW'(key_count);
		end
	end
	assign last_idx = IW'(n_keys - CW'(1));
	assign t_eval   = job_q.req.eval_time;

	// key table write
	assign wr_en = (state_q == S_START) && (job_q.kind == kce_pkg::JOB_WRITE);
	assign wr_rec = '{ktime: job_q.req.key_time, kvalue: job_q.req.key_value,
		kin: job_q.req.key_in_tangent, kout: job_q.req.key_out_tangent,
		kmode: job_q.req.key_mode};

	// read address by state
	always_comb begin
		unique case (state_q)
			S_START: rd_addr = '0;
			S_CK0:   rd_addr = last_idx;
			S_CKL:   rd_addr = IW'(1);
			S_SCAN:  rd_addr = idx_q + IW'(1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[IW'(job_q.req.key_index)] <= wr_rec;
		end
		rd_data_q <= key_mem[rd_addr];
	end

	// segment span and offset from the scan hit
	assign span_c = $signed({rd_data_q.ktime[31], rd_data_q.ktime})
		- $signed({prev_q.ktime[31], prev_q.ktime});
	assign off_c  = $signed({t_eval[31], t_eval}) - $signed({prev_q.ktime[31], prev_q.ktime});

	// one restoring divide step
	assign rem2 = {rem_q[32:0], 1'b0};
	assign qbit = (rem2 >= {1'b0, span_q});

	// shared multiplier operands
	always_comb begin
		opa = '0;
		opb = '0;
		case (step_q)
			ST_LIN: begin
				opa = 34'($signed({right_q.kvalue[31], right_q.kvalue})
					- $signed({left_q.kvalue[31], left_q.kvalue}));
				opb = $signed({17'd0, a_q});
			end
			ST_A2: begin
				opa = $signed({17'd0, a_q});
				opb = $signed({17'd0, a_q});
			end
			ST_A3: begin
				opa = $signed({18'd0, a2_q});
				opb = $signed({17'd0, a_q});
			end
			ST_H00: begin
				opa = 34'(h00_q);
				opb = 34'(left_q.kvalue);
			end
			ST_H01: begin
				opa = 34'(h01_q);
				opb = 34'(right_q.kvalue);
			end
			ST_P10: begin
				opa = 34'(h10_q);
				opb = 34'(span_q);
			end
			ST_S10: begin
				opa = 34'(p_q);
				opb = 34'(left_q.kout);
			end
			ST_P11: begin
				opa = 34'(h11_q);
				opb = 34'(span_q);
			end
			ST_S11: begin
				opa = 34'(p_q);
				opb = 34'(right_q.kin);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// product floored to Q16.16
	assign term = kce_pkg::ACC_W'(prod_q >>> 16);

	assign ae  = $signed({4'd0, a_q[15:0]});
	assign a2e = $signed({4'd0, a2_q});
	assign a3e = $signed({4'd0, a3_q});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_LIN;
			done_q  <= 1'b0;
			idx_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!qstat.empty) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (job_q.kind == kce_pkg::JOB_EVAL) begin
						if (n_keys == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_CK0;
						end
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CK0: begin
					if (t_eval <= rd_data_q.ktime) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CKL;
					end
				end
				S_CKL: begin
					if (t_eval >= rd_data_q.ktime) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= IW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if ((rd_data_q.ktime > t_eval) || (idx_q == last_idx)) begin
						state_q <= S_DIVI;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_DIVI: begin
					if ((span_q <= 0) || (off_q < 0) || (off_q >= span_q)) begin
						state_q <= S_MODE;
					end else begin
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'd15) begin
						state_q <= S_MODE;
					end
				end
				S_MODE: begin
					unique case (left_q.kmode)
						kce_pkg::MODE_LINEAR: begin
							step_q  <= ST_LIN;
							state_q <= S_MUL;
						end
						kce_pkg::MODE_CUBIC: begin
							step_q  <= ST_A2;
							state_q <= S_MUL;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					case (step_q) inside
						ST_LIN, ST_S11: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						ST_A2: begin
							step_q  <= ST_A3;
							state_q <= S_MUL;
						end
						ST_A3: begin
							state_q <= S_HERM;
						end
						ST_H00: begin
							step_q  <= ST_H01;
							state_q <= S_MUL;
						end
						ST_H01: begin
							step_q  <= ST_P10;
							state_q <= S_MUL;
						end
						ST_P10: begin
							step_q  <= ST_S10;
							state_q <= S_MUL;
						end
						ST_S10: begin
							step_q  <= ST_P11;
							state_q <= S_MUL;
						end
						ST_P11: begin
							step_q  <= ST_S11;
							state_q <= S_MUL;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_HERM: begin
					step_q  <= ST_H00;
					state_q <= S_MUL;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !qstat.empty) begin
			job_q <= head;
		end
		if (state_q == S_CK0) begin
			prev_q <= rd_data_q;
		end
		if (state_q == S_SCAN) begin
			if ((rd_data_q.ktime > t_eval) || (idx_q == last_idx)) begin
				left_q  <= prev_q;
				right_q <= rd_data_q;
				span_q  <= span_c;
				off_q   <= off_c;
			end else begin
				prev_q <= rd_data_q;
			end
		end
		if (state_q == S_DIVI) begin
			rem_q <= {1'b0, off_q};
			quo_q <= '0;
			if ((span_q <= 0) || (off_q < 0)) begin
				a_q <= '0;
			end else if (off_q >= span_q) begin
				a_q <= 17'd65535;
			end
		end
		if (state_q == S_DIV) begin
			rem_q <= qbit ? (rem2 - {1'b0, span_q}) : rem2;
			quo_q <= {quo_q[14:0], qbit};
			if (dcnt_q == 4'd15) begin
				a_q <= {1'b0, quo_q[14:0], qbit};
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= opa * opb;
		end
		if (state_q == S_ACC) begin
			case (step_q) inside
				ST_A2: a2_q <= prod_q[31:16];
				ST_A3: a3_q <= prod_q[31:16];
				ST_H00: acc_q <= term;
				ST_H01, ST_S10: acc_q <= acc_q + term;
				ST_P10, ST_P11: p_q <= kce_pkg::sat32(term);
				default: acc_q <= acc_q;
			endcase
		end
		if (state_q == S_HERM) begin
			h00_q <= 20'sd2 * a3e - 20'sd3 * a2e + 20'sd65536;
			h10_q <= a3e - 20'sd2 * a2e + ae;
			h01_q <= 20'sd3 * a2e - 20'sd2 * a3e;
			h11_q <= a3e - a2e;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		res_q.status      <= kce_pkg::STAT_EVAL;
		res_q.curve_value <= '0;
		unique case (state_q) inside
			S_START: begin
				if (job_q.kind == kce_pkg::JOB_WRITE) begin
					res_q.status <= kce_pkg::STAT_WRITTEN;
				end else if (job_q.kind == kce_pkg::JOB_REJECT) begin
					res_q.status <= kce_pkg::STAT_REJECT;
				end
			end
			S_CK0, S_CKL: res_q.curve_value <= rd_data_q.kvalue;
			S_MODE: res_q.curve_value <= left_q.kvalue;
			S_ACC: begin
				if (step_q == ST_LIN) begin
					res_q.curve_value <= kce_pkg::sat32(
						kce_pkg::ACC_W'(left_q.kvalue) + term);
				end else begin
					res_q.curve_value <= kce_pkg::sat32(acc_q + term);
				end
			end
			default: res_q.curve_value <= '0;
		endcase
	end

	assign pop  = (state_q == S_IDLE) && !qstat.empty;
	assign done = done_q;
	assign res  = res_q;

endmodule
